// ===== rtl/core/bmp_pkg.sv =====
package bmp_pkg;

  localparam logic [1:0] MODE_PAL8  = 2'd0;
  localparam logic [1:0] MODE_RGB24 = 2'd1;
  localparam logic [1:0] MODE_RGB32 = 2'd2;

  localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  localparam int unsigned CfgDataW  = 13;
  localparam logic [12:0] WIDTH_MAX  = 13'd4096;
  localparam logic [12:0] HEIGHT_MAX = 13'd4096;

  typedef struct packed {
    logic [1:0]  pixel_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       from_palette;
    logic       palette_hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] extra_byte;
    logic       last_pixel;
  } pix_res_t;

endpackage

// ===== rtl/core/bmp_in_if.sv =====
interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] palette_slot;
  logic [7:0] entry_blue;
  logic [7:0] entry_green;
  logic [7:0] entry_red;

  modport source (
    output valid, kind, data_byte, palette_slot, entry_blue, entry_green, entry_red,
    input  ready
  );
  modport sink (
    input  valid, kind, data_byte, palette_slot, entry_blue, entry_green, entry_red,
    output ready
  );
endinterface

// ===== rtl/core/bmp_out_if.sv =====
interface bmp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] extra_byte;
  logic       last_pixel;

  modport source (
    output valid, red, green, blue, extra_byte, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, extra_byte, last_pixel,
    output ready
  );
endinterface

// ===== rtl/core/bmp_pal_ram.sv =====
module bmp_pal_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [23:0]              wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [23:0]              rd_data_o
);

  logic [23:0] mem_q [DEPTH];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/bmp_unpack_ctrl.sv =====
module bmp_unpack_ctrl import bmp_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  output pix_res_t   res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [23:0] held_q, held_d;
  logic [11:0] col_q, col_d;
  logic [1:0]  pad_q, pad_d;
  logic [11:0] row_q, row_d;

  logic [12:0] eff_w, eff_h;
  logic [2:0]  bpp;
  logic [4:0]  row_prod;
  logic [12:0] col_next, row_next;
  logic        done;

  always_comb begin
    eff_w = cfg_i.image_width;
    if (eff_w == 13'd0) eff_w = 13'd1;
    if (eff_w > WIDTH_MAX) eff_w = WIDTH_MAX;
    eff_h = cfg_i.image_height;
    if (eff_h == 13'd0) eff_h = 13'd1;
    if (eff_h > HEIGHT_MAX) eff_h = HEIGHT_MAX;
    unique case (cfg_i.pixel_mode)
      MODE_PAL8:  bpp = 3'd1;
      MODE_RGB24: bpp = 3'd3;
      default:    bpp = 3'd4;
    endcase
    row_prod = {3'b000, eff_w[1:0]} * {2'b00, bpp};
  end

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    col_d    = col_q;
    pad_d    = pad_q;
    row_d    = row_q;
    res_o    = '0;
    done     = 1'b0;
    col_next = {1'b0, col_q} + 13'd1;
    row_next = {1'b0, row_q} + 13'd1;
    if (step_i) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else begin
        if (cfg_i.pixel_mode == MODE_PAL8) begin
          done               = 1'b1;
          res_o.from_palette = 1'b1;
          res_o.palette_hit  = ({1'b0, data_byte_i} < 9'(PALETTE_DEPTH));
        end else if (({1'b0, phase_q} + 3'd1) < bpp) begin
          case (phase_q)
            2'd0:    held_d = held_q | {16'd0, data_byte_i};
            2'd1:    held_d = held_q | {8'd0, data_byte_i, 8'd0};
            2'd2:    held_d = held_q | {data_byte_i, 16'd0};
            default: held_d = held_q;
          endcase
          phase_d = phase_q + 2'd1;
        end else begin
          done        = 1'b1;
          res_o.blue  = held_q[7:0];
          res_o.green = held_q[15:8];
          if (bpp == 3'd3) begin
            res_o.red = data_byte_i;
          end else begin
            res_o.red        = held_q[23:16];
            res_o.extra_byte = data_byte_i;
          end
        end
        if (done) begin
          res_o.valid = 1'b1;
          phase_d     = 2'd0;
          held_d      = 24'd0;
          if (col_next >= eff_w) begin
            pad_d = 2'd0 - row_prod[1:0];
            col_d = 12'd0;
            if (row_next >= eff_h) begin
              res_o.last_pixel = 1'b1;
              row_d            = 12'd0;
            end else begin
              row_d = row_next[11:0];
            end
          end else begin
            col_d = col_next[11:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= 24'd0;
      col_q   <= 12'd0;
      pad_q   <= 2'd0;
      row_q   <= 12'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      col_q   <= col_d;
      pad_q   <= pad_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== rtl/core/bmp_scanline_pixel_unpacker_unit.sv =====
// Channel  Direction  Beat contents
// in_i     sink       kind, data_byte, palette_slot, entry_blue, entry_green, entry_red
// out_o    source     red, green, blue, extra_byte, last_pixel
// cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i (no read-back)
//
// One beat per cycle unless the output stalls; a pixel appears the cycle after its last byte.
// The palette RAM read is registered and captured with the pixel in the output stage.
// A stalled output holds the input only when the output register is full and not taken.
// Reset clears counters, held bytes, out valid; cfg is 32-bit 1x1; palette holds garbage until loaded.
module bmp_scanline_pixel_unpacker_unit import bmp_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bmp_in_if.sink              in_i,
  bmp_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(PALETTE_DEPTH);

  cfg_t     cfg_q;
  pix_res_t step_res;
  pix_res_t res_q;
  logic     out_valid_q, out_valid_d;
  logic     accept;
  logic     pal_wr_en;
  logic [23:0] pal_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode   <= MODE_RGB32;
      cfg_q.image_width  <= 13'd1;
      cfg_q.image_height <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIXEL_MODE:   cfg_q.pixel_mode   <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pal_wr_en  = accept && (in_i.kind == KIND_PALETTE)
                      && ({1'b0, in_i.palette_slot} < 9'(PALETTE_DEPTH));

  bmp_pal_ram #(
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pal_wr_en),
    .wr_addr_i (in_i.palette_slot[IdxW-1:0]),
    .wr_data_i ({in_i.entry_red, in_i.entry_green, in_i.entry_blue}),
    .rd_en_i   (accept && (in_i.kind == KIND_PIXEL)),
    .rd_addr_i (in_i.data_byte[IdxW-1:0]),
    .rd_data_o (pal_rd_data)
  );

  bmp_unpack_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (accept && (in_i.kind == KIND_PIXEL)),
    .data_byte_i (in_i.data_byte),
    .res_o       (step_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && step_res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step_res.valid) begin
      res_q <= step_res;
    end
  end

  always_comb begin
    out_o.valid      = out_valid_q;
    out_o.extra_byte = res_q.extra_byte;
    out_o.last_pixel = res_q.last_pixel;
    if (res_q.from_palette) begin
      if (res_q.palette_hit) begin
        out_o.red   = pal_rd_data[23:16];
        out_o.green = pal_rd_data[15:8];
        out_o.blue  = pal_rd_data[7:0];
      end else begin
        out_o.red   = 8'd0;
        out_o.green = 8'd0;
        out_o.blue  = 8'd0;
      end
    end else begin
      out_o.red   = res_q.red;
      out_o.green = res_q.green;
      out_o.blue  = res_q.blue;
    end
  end

endmodule

// ===== tb/sv/bmp_scanline_pixel_unpacker_unit_tb.sv =====
module bmp_scanline_pixel_unpacker_unit_tb;
  import bmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Mode 3 has no name of its own in the package; the block decodes it as 32-bit.
  localparam logic [1:0] MODE_RGB32_ALIAS = 2'd3;
  localparam int unsigned RandomBeats = 1700;
  localparam int unsigned PrintLimit  = 100;

  typedef struct packed {
    bit       kind;
    bit [7:0] data_byte;
    bit [7:0] palette_slot;
    bit [7:0] entry_blue;
    bit [7:0] entry_green;
    bit [7:0] entry_red;
  } px_beat_t;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] extra_byte;
    bit       last_pixel;
  } pixel_t;

  class pixel_tracker;
    bit [23:0] color_table [256];
    bit        loaded [256];
    bit [7:0]  loaded_slots [$];
    bit [1:0]  mode;
    bit [12:0] width;
    bit [12:0] height;
    bit [1:0]  byte_phase;
    bit [23:0] held_bytes;
    bit [11:0] column_count;
    bit [1:0]  pad_left;
    bit [11:0] row_count;
    pixel_t    expected_pixels [$];
    int        errors;
    int        checked;

    function new();
      mode         = MODE_RGB32;
      width        = 13'd1;
      height       = 13'd1;
      byte_phase   = '0;
      held_bytes   = '0;
      column_count = '0;
      pad_left     = '0;
      row_count    = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_PIXEL_MODE:   mode = value[1:0];
        CFG_IMAGE_WIDTH:  width = value;
        CFG_IMAGE_HEIGHT: height = value;
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width == 0) return 1;
      if (width > WIDTH_MAX) return WIDTH_MAX;
      return width;
    endfunction

    function int unsigned eff_height();
      if (height == 0) return 1;
      if (height > HEIGHT_MAX) return HEIGHT_MAX;
      return height;
    endfunction

    function int unsigned bytes_per_pixel();
      if (mode == MODE_PAL8) return 1;
      if (mode == MODE_RGB24) return 3;
      return 4;
    endfunction

    function bit reads_palette();
      return pad_left == 0 && mode == MODE_PAL8;
    endfunction

    function bit [7:0] usable_index(bit [7:0] want);
      if (loaded[want] || loaded_slots.size() == 0) return want;
      return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_beat(px_beat_t b);
      int unsigned bpp;
      int unsigned cnt;
      int unsigned rem;
      pixel_t p;
      if (b.kind == KIND_PALETTE) begin
        color_table[b.palette_slot] = {b.entry_red, b.entry_green, b.entry_blue};
        if (!loaded[b.palette_slot]) loaded_slots.push_back(b.palette_slot);
        loaded[b.palette_slot] = 1'b1;
        return;
      end
      if (pad_left != 0) begin
        pad_left = pad_left - 2'd1;
        return;
      end
      bpp = bytes_per_pixel();
      p = '0;
      if (bpp == 1) begin
        {p.red, p.green, p.blue} = color_table[b.data_byte];
      end else if (byte_phase + 1 < bpp) begin
        held_bytes = held_bytes | (24'(b.data_byte) << (8 * byte_phase));
        byte_phase = byte_phase + 2'd1;
        return;
      end else if (bpp == 3) begin
        p.blue  = held_bytes[7:0];
        p.green = held_bytes[15:8];
        p.red   = b.data_byte;
      end else begin
        p.blue       = held_bytes[7:0];
        p.green      = held_bytes[15:8];
        p.red        = held_bytes[23:16];
        p.extra_byte = b.data_byte;
      end
      byte_phase = '0;
      held_bytes = '0;
      cnt = column_count + 1;
      if (cnt >= eff_width()) begin
        rem = (eff_width() * bpp) % 4;
        pad_left = (rem == 0) ? 2'd0 : 2'(4 - rem);
        cnt = 0;
        if (row_count + 1 >= eff_height()) begin
          p.last_pixel = 1'b1;
          row_count = '0;
        end else begin
          row_count = row_count + 12'd1;
        end
      end
      column_count = cnt[11:0];
      expected_pixels.push_back(p);
    endfunction

    task report(string msg);
      if (errors < PrintLimit) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      checked++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel %0d arrived with none pending: r %02h g %02h b %02h",
                         checked, got.red, got.green, got.blue));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red != want.red)
        report($sformatf("pixel %0d red %02h, want %02h", checked, got.red, want.red));
      if (got.green != want.green)
        report($sformatf("pixel %0d green %02h, want %02h", checked, got.green, want.green));
      if (got.blue != want.blue)
        report($sformatf("pixel %0d blue %02h, want %02h", checked, got.blue, want.blue));
      if (got.extra_byte != want.extra_byte)
        report($sformatf("pixel %0d extra byte %02h, want %02h",
                         checked, got.extra_byte, want.extra_byte));
      if (got.last_pixel != want.last_pixel)
        report($sformatf("pixel %0d last flag %0b, want %0b",
                         checked, got.last_pixel, want.last_pixel));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bmp_in_if  px_in ();
  bmp_out_if px_out ();

  bmp_scanline_pixel_unpacker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (px_in),
    .out_o      (px_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pixel_tracker pixels;
  pixel_t       got_pixel;
  int unsigned  beats_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  src_calm = 0;
  int unsigned  snk_calm = 0;
  int unsigned  hold_left = 0;
  int unsigned  snk_roll;
  bit           long_hold_done = 1'b0;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned src_gap();
    int unsigned r;
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      src_calm = $urandom_range(50, 300);
      return 0;
    end
    if (r < 4) return $urandom_range(10, 40);
    if (r < 25) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic px_beat_t pixel_beat(bit [7:0] raw);
    px_beat_t b;
    b.kind         = KIND_PIXEL;
    b.data_byte    = pixels.reads_palette() ? pixels.usable_index(raw) : raw;
    b.palette_slot = 8'($urandom);
    b.entry_blue   = 8'($urandom);
    b.entry_green  = 8'($urandom);
    b.entry_red    = 8'($urandom);
    return b;
  endfunction

  function automatic px_beat_t load_beat(bit [7:0] slot, bit [7:0] blue, bit [7:0] green,
                                         bit [7:0] red);
    px_beat_t b;
    b.kind         = KIND_PALETTE;
    b.data_byte    = 8'($urandom);
    b.palette_slot = slot;
    b.entry_blue   = blue;
    b.entry_green  = green;
    b.entry_red    = red;
    return b;
  endfunction

  task automatic send_beat(input px_beat_t b);
    int unsigned gap;
    gap = src_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      px_in.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    px_in.kind         <= b.kind;
    px_in.data_byte    <= b.data_byte;
    px_in.palette_slot <= b.palette_slot;
    px_in.entry_blue   <= b.entry_blue;
    px_in.entry_green  <= b.entry_green;
    px_in.entry_red    <= b.entry_red;
    px_in.valid        <= 1'b1;
    do @(posedge clk_i); while (px_in.ready !== 1'b1);
    pixels.note_beat(b);
    beats_sent++;
  endtask

  task automatic send_random_load();
    send_beat(load_beat(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    px_in.valid <= 1'b0;
    while (pixels.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    pixels.configure(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_format(input logic [1:0] mode, input int unsigned w, input int unsigned h);
    write_reg(CFG_PIXEL_MODE, CfgDataW'(mode));
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(w));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(h));
  endtask

  task automatic run_directed();
    repeat (4) send_beat(pixel_beat(8'h00));
    repeat (4) send_beat(pixel_beat(8'hFF));
    drain();
    set_format(MODE_PAL8, 3, 2);
    send_beat(load_beat(8'h00, 8'h00, 8'hFF, 8'h00));
    send_beat(load_beat(8'hFF, 8'hFF, 8'h00, 8'hFF));
    send_beat(load_beat(8'h5A, 8'h12, 8'h34, 8'h56));
    send_beat(pixel_beat(8'hFF));
    send_beat(pixel_beat(8'h00));
    send_beat(pixel_beat(8'h5A));
    send_beat(pixel_beat(8'hFF));
    send_beat(pixel_beat(8'h5A));
    send_beat(pixel_beat(8'hFF));
    send_beat(pixel_beat(8'h00));
    send_beat(pixel_beat(8'h00));
    drain();
    set_format(MODE_RGB24, 1, 1);
    send_beat(pixel_beat(8'h01));
    send_beat(pixel_beat(8'h80));
    send_beat(pixel_beat(8'hFE));
    send_beat(pixel_beat(8'h7F));
    drain();
    set_format(MODE_RGB32_ALIAS, 0, 0);
    send_beat(pixel_beat(8'hAA));
    send_beat(pixel_beat(8'h55));
    send_beat(pixel_beat(8'h0F));
    send_beat(pixel_beat(8'hF0));
  endtask

  task automatic random_phase();
    logic [1:0]  mode;
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned bpp;
    int unsigned row_bytes;
    int unsigned frame_bytes;
    int unsigned nbytes;
    r = $urandom_range(0, 9);
    mode = (r < 3) ? MODE_PAL8 : (r < 6) ? MODE_RGB24 : (r < 9) ? MODE_RGB32 : MODE_RGB32_ALIAS;
    r = $urandom_range(0, 19);
    case (r)
      0: w = 0;
      1: w = WIDTH_MAX;
      2: w = $urandom_range(WIDTH_MAX + 1, 8191);
      3: w = 8191;
      4: w = $urandom_range(10, 64);
      default: w = $urandom_range(1, 9);
    endcase
    r = $urandom_range(0, 19);
    case (r)
      0: h = 0;
      1: h = HEIGHT_MAX;
      2: h = $urandom_range(HEIGHT_MAX + 1, 8191);
      3: h = 8191;
      4: h = $urandom_range(4, 8);
      default: h = $urandom_range(1, 3);
    endcase
    drain();
    set_format(mode, w, h);
    bpp = (mode == MODE_PAL8) ? 1 : (mode == MODE_RGB24) ? 3 : 4;
    if (w == 0) w = 1;
    if (w > WIDTH_MAX) w = WIDTH_MAX;
    if (h == 0) h = 1;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    row_bytes = w * bpp;
    row_bytes = row_bytes + (4 - row_bytes % 4) % 4;
    frame_bytes = row_bytes * h;
    if (frame_bytes > 600) nbytes = $urandom_range(16, 200);
    else nbytes = frame_bytes * $urandom_range(1, 3);
    r = $urandom_range(0, 7);
    if (r == 0) nbytes = $urandom_range(1, nbytes);
    else if (r == 1) nbytes = nbytes + $urandom_range(1, 5);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(4, 32)) send_random_load();
    repeat (nbytes) begin
      if ($urandom_range(0, 11) == 0) send_random_load();
      send_beat(pixel_beat(8'($urandom)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && px_out.valid && px_out.ready) begin
      got_pixel.red        = px_out.red;
      got_pixel.green      = px_out.green;
      got_pixel.blue       = px_out.blue;
      got_pixel.extra_byte = px_out.extra_byte;
      got_pixel.last_pixel = px_out.last_pixel;
      pixels.check_pixel(got_pixel);
      results_seen++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        px_out.ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left = 299;
        px_out.ready <= 1'b0;
      end else if (snk_calm > 0) begin
        px_out.ready <= 1'b1;
        snk_calm--;
      end else begin
        snk_roll = $urandom_range(0, 99);
        if (snk_roll < 2) begin
          snk_calm = $urandom_range(50, 300);
          px_out.ready <= 1'b1;
        end else if (snk_roll < 4) begin
          hold_left = $urandom_range(9, 49);
          px_out.ready <= 1'b0;
        end else if (snk_roll < 22) begin
          hold_left = $urandom_range(0, 2);
          px_out.ready <= 1'b0;
        end else begin
          px_out.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #(25_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned random_start;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_PIXEL_MODE;
    cfg_data_i         = '0;
    px_in.valid        = 1'b0;
    px_in.kind         = KIND_PIXEL;
    px_in.data_byte    = '0;
    px_in.palette_slot = '0;
    px_in.entry_blue   = '0;
    px_in.entry_green  = '0;
    px_in.entry_red    = '0;
    px_out.ready       = 1'b0;
    pixels = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    drain();
    for (int s = 0; s < 256; s++) begin
      send_beat(load_beat(8'(s), 8'($urandom), 8'($urandom), 8'($urandom)));
    end
    random_start = beats_sent;
    while (beats_sent - random_start < RandomBeats) random_phase();

    drain();
    repeat (8) @(posedge clk_i);

    if (pixels.errors == 0 && pixels.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
